// ===== rtl/mppt_perturb_observe_top_defines.svh =====
// assertion macros for the perturb and observe tracker
`ifndef MPPT_PERTURB_OBSERVE_TOP_DEFINES_SVH
`define MPPT_PERTURB_OBSERVE_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during rst
`define MPPT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define MPPT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/mppt_po_pkg.sv =====
// shared types and constants of the perturb and observe tracker
package mppt_po_pkg;

  localparam int MV_W        = 16;
  localparam int MA_W        = 16;
  localparam int PWR_W       = 32;
  localparam int IN_DATA_W   = 48;
  localparam int OUT_DATA_W  = 80;
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 32;

  localparam logic [PWR_W-1:0] BIG_DELTA_UW = 32'd60000;

  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_SET     = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_POWER_RES   = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_LARGE_STEP  = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SMALL_STEP  = 4'd3;

  localparam logic [MV_W-1:0]  MAX_SET_RST    = 16'd65535;
  localparam logic [PWR_W-1:0] POWER_RES_RST  = 32'd10000;
  localparam logic [MV_W-1:0]  LARGE_STEP_RST = 16'd200;
  localparam logic [MV_W-1:0]  SMALL_STEP_RST = 16'd10;

  typedef struct packed {
    logic [MV_W-1:0] sample_mv;
    logic [MA_W-1:0] sample_ma;
    logic [MV_W-1:0] floor_mv;
  } in_beat_t;

  typedef struct packed {
    logic [PWR_W-1:0] power;
    logic [PWR_W-1:0] prev_power;
    logic             v_up;
    logic [MV_W-1:0]  sample_mv;
    logic [MA_W-1:0]  sample_ma;
    logic [MV_W-1:0]  floor_mv;
  } pow_beat_t;

  typedef struct packed {
    logic [MV_W-1:0]  max_set_mv;
    logic [PWR_W-1:0] power_resolution_uw;
    logic [MV_W-1:0]  large_step_mv;
    logic [MV_W-1:0]  small_step_mv;
  } cfg_t;

  typedef struct packed {
    logic [MV_W-1:0]  set_point_mv;
    logic [PWR_W-1:0] peak_power_uw;
    logic [MV_W-1:0]  peak_mv;
    logic [MA_W-1:0]  peak_ma;
  } result_t;

endpackage

// ===== rtl/mppt_po_power.sv =====
// power stage: sample power, previous power and voltage direction
module mppt_po_power (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  mppt_po_pkg::in_beat_t in_beat,
  output logic                  out_valid,
  input  logic                  out_ready,
  output mppt_po_pkg::pow_beat_t out_beat
);
  import mppt_po_pkg::*;

  logic [MV_W-1:0]  prev_mv;
  logic [PWR_W-1:0] prev_power;
  logic [PWR_W-1:0] power;
  logic             fire;

  assign power    = {16'd0, in_beat.sample_mv} * {16'd0, in_beat.sample_ma};
  assign in_ready = !out_valid || out_ready;
  assign fire     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      prev_mv    <= '0;
      prev_power <= '0;
    end else begin
      if (in_ready) begin
        out_valid <= in_valid;
      end
      if (fire) begin
        prev_mv    <= in_beat.sample_mv;
        prev_power <= power;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_beat.power      <= power;
      out_beat.prev_power <= prev_power;
      out_beat.v_up       <= (in_beat.sample_mv >= prev_mv);
      out_beat.sample_mv  <= in_beat.sample_mv;
      out_beat.sample_ma  <= in_beat.sample_ma;
      out_beat.floor_mv   <= in_beat.floor_mv;
    end
  end

endmodule

// ===== rtl/mppt_po_track.sv =====
// tracking stage: step decision, set point clamp and peak record
`include "mppt_perturb_observe_top_defines.svh"

module mppt_po_track (
  input  logic                   clk,
  input  logic                   rst,
  input  mppt_po_pkg::cfg_t      cfg,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  mppt_po_pkg::pow_beat_t in_beat,
  output logic                   out_valid,
  input  logic                   out_ready,
  output mppt_po_pkg::result_t   result
);
  import mppt_po_pkg::*;

  logic [MV_W-1:0]     set_point;
  logic [PWR_W-1:0]    peak_power;
  logic [MV_W-1:0]     peak_mv;
  logic [MA_W-1:0]     peak_ma;
  logic                fire;

  logic signed [33:0]  dp;
  logic signed [33:0]  res_s;
  logic signed [33:0]  big_s;
  logic                big;
  logic                rise;
  logic                drop;
  logic                move_up;
  logic [MV_W-1:0]     step;
  logic signed [17:0]  sp_step;
  logic signed [17:0]  sp_floor;
  logic [MV_W-1:0]     set_point_next;
  logic                peak_take;

  assign in_ready = !out_valid || out_ready;
  assign fire     = in_valid && in_ready;

  assign dp    = $signed({2'b00, in_beat.power}) - $signed({2'b00, in_beat.prev_power});
  assign res_s = $signed({2'b00, cfg.power_resolution_uw});
  assign big_s = $signed({2'b00, BIG_DELTA_UW});
  assign big   = (dp > big_s) || (dp < -big_s);
  assign rise  = dp > res_s;
  assign drop  = dp < -res_s;
  assign step  = big ? cfg.large_step_mv : cfg.small_step_mv;

  assign move_up = (rise && in_beat.v_up) || (drop && !in_beat.v_up);

  always_comb begin
    if (!rise && !drop) begin
      sp_step = $signed({2'b00, set_point});
    end else if (move_up) begin
      sp_step = $signed({2'b00, set_point}) + $signed({2'b00, step});
    end else begin
      sp_step = $signed({2'b00, set_point}) - $signed({2'b00, step});
    end
    if (sp_step < $signed({2'b00, in_beat.floor_mv})) begin
      sp_floor = $signed({2'b00, in_beat.floor_mv});
    end else begin
      sp_floor = sp_step;
    end
    if (sp_floor > $signed({2'b00, cfg.max_set_mv})) begin
      set_point_next = cfg.max_set_mv;
    end else begin
      set_point_next = sp_floor[MV_W-1:0];
    end
  end

  assign peak_take = !rise && !drop && (peak_power < in_beat.power);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      set_point  <= '0;
      peak_power <= '0;
      peak_mv    <= '0;
      peak_ma    <= '0;
    end else begin
      if (in_ready) begin
        out_valid <= in_valid;
      end
      if (fire) begin
        set_point <= set_point_next;
        if (peak_take) begin
          peak_power <= in_beat.power;
          peak_mv    <= in_beat.sample_mv;
          peak_ma    <= in_beat.sample_ma;
        end
      end
    end
  end

  assign result.set_point_mv  = set_point;
  assign result.peak_power_uw = peak_power;
  assign result.peak_mv       = peak_mv;
  assign result.peak_ma       = peak_ma;

  `MPPT_ASSERT_NEXT(a_peak_monotonic, fire, peak_power >= $past(peak_power), "peak power fell")
  `MPPT_ASSERT_NOW(a_peak_product, 1'b1, peak_power == 32'(peak_mv) * 32'(peak_ma),
    "peak power does not match its voltage and current")
  `MPPT_ASSERT_NEXT(a_hold_state, !fire,
    $stable(set_point) && $stable(peak_power) && $stable(peak_mv) && $stable(peak_ma),
    "tracker state moved without a beat")
  `MPPT_ASSERT_NEXT(a_result_valid, fire, out_valid, "no result after a tracked beat")

endmodule

// ===== rtl/mppt_perturb_observe_top.sv =====
// top level of the perturb and observe maximum power point tracker
//
// s_tdata carries one panel sample per beat (voltage, current, floor) and
// m_tdata returns one result per beat: the new voltage set point and the
// recorded peak power with its voltage and current.
// the cfg channel writes one register per beat by index; cfg_ready is always
// high and writes to unknown indexes are dropped. write registers only while
// no sample is in flight.
// a sample taken into the input register passes the power register, then the
// tracker register, before it shows on m_tdata.
// throughput: one sample per cycle while m_tready is high; the 16x16 multiply
// sits in its own stage and the set point and peak update in the last stage,
// so each sample sees the state left by the one before it.
// when m_tready is low the result holds, and up to two more samples are
// taken into the earlier stages before s_tready drops.
// rst (synchronous, active high) empties the pipeline, clears the previous
// sample, set point and peak record to zero and loads register defaults.
module mppt_perturb_observe_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // sample_mv[15:0], sample_ma[31:16], floor_mv[47:32]
  input  logic [mppt_po_pkg::IN_DATA_W-1:0]    s_tdata,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // set_point_mv[15:0], peak_power_uw[47:16], peak_mv[63:48], peak_ma[79:64]
  output logic [mppt_po_pkg::OUT_DATA_W-1:0]   m_tdata,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [mppt_po_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [mppt_po_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import mppt_po_pkg::*;

  cfg_t      cfg;
  logic      a_valid;
  logic      a_ready;
  in_beat_t  a_beat;
  logic      b_valid;
  logic      b_ready;
  pow_beat_t b_beat;
  result_t   result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_set_mv          <= MAX_SET_RST;
      cfg.power_resolution_uw <= POWER_RES_RST;
      cfg.large_step_mv       <= LARGE_STEP_RST;
      cfg.small_step_mv       <= SMALL_STEP_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MAX_SET:    cfg.max_set_mv          <= cfg_data[MV_W-1:0];
        CFG_POWER_RES:  cfg.power_resolution_uw <= cfg_data[PWR_W-1:0];
        CFG_LARGE_STEP: cfg.large_step_mv       <= cfg_data[MV_W-1:0];
        CFG_SMALL_STEP: cfg.small_step_mv       <= cfg_data[MV_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  assign s_tready = !a_valid || a_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (s_tready) begin
      a_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      a_beat.sample_mv <= s_tdata[15:0];
      a_beat.sample_ma <= s_tdata[31:16];
      a_beat.floor_mv  <= s_tdata[47:32];
    end
  end

  mppt_po_power u_power (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (a_valid),
    .in_ready  (a_ready),
    .in_beat   (a_beat),
    .out_valid (b_valid),
    .out_ready (b_ready),
    .out_beat  (b_beat)
  );

  mppt_po_track u_track (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (b_valid),
    .in_ready  (b_ready),
    .in_beat   (b_beat),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .result    (result)
  );

  assign m_tdata[15:0]  = result.set_point_mv;
  assign m_tdata[47:16] = result.peak_power_uw;
  assign m_tdata[63:48] = result.peak_mv;
  assign m_tdata[79:64] = result.peak_ma;

endmodule
